[hw/rtl/horner_string_hash_mod_assert.svh]
// Assertion macros shared by the hash block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef HORNER_STRING_HASH_MOD_ASSERT_SVH
`define HORNER_STRING_HASH_MOD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSHM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSHM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hshm_pkg.sv]
package hshm_pkg;

    // Horner radix and character classes.
    localparam int unsigned HORNER_RADIX = 64;
    localparam int unsigned LETTER_COUNT = 26;
    localparam int unsigned DOUBLE       = 2;
    localparam int unsigned CODE_W       = $clog2(HORNER_RADIX);

    // Field widths of the channels.
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned OUT_W     = 16;
    localparam int unsigned MOD_REG_W = 16;

    // Hash datapath default.
    localparam int unsigned HASH_WIDTH_DEFAULT = 16;

    // Register file.
    localparam int unsigned    ADDR_W        = 3;
    localparam int unsigned    DATA_W        = 32;
    localparam logic           REG_MODULUS   = 1'b0;
    localparam logic [MOD_REG_W-1:0] MODULUS_RESET = 16'd65521;

    // ASCII bounds of the alphanumeric classes.
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } char_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] hash_value;
        logic             bad_char;
    } hash_item_t;

    typedef struct packed {
        logic              bad;
        logic [CODE_W-1:0] code;
    } char_code_t;

    // Maps a character to its 6-bit code; anything outside the classes gives 0 and bad.
    function automatic char_code_t char_code(input logic [CHAR_W-1:0] ch);
        char_code_t        res;
        logic [CHAR_W-1:0] tmp;
        res = '0;
        tmp = '0;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            tmp = ch - CHAR_LOWER_A;
        end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            tmp = ch - CHAR_UPPER_A + CHAR_W'(LETTER_COUNT);
        end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
            tmp = ch - CHAR_DIGIT_0 + CHAR_W'(DOUBLE * LETTER_COUNT);
        end else begin
            res.bad = 1'b1;
        end
        res.code = tmp[CODE_W-1:0];
        return res;
    endfunction

endpackage

[hw/rtl/horner_string_hash_mod.sv]
// Channel   Role     Payload       Handshake
// char      input    char_item_t   char_valid / char_stall
// hash      output   hash_item_t   hash_valid / hash_stall
// apb       config   modulus       psel / penable / pwrite, pready tied high
//
// A character whose stored remainder is below the modulus takes the
// transfer cycle and six steps of the shared shift, compare and subtract unit.
// When the remainder is not below the modulus (it was changed mid-string), the
// unit divides the whole remainder together with the character code.
// Reset clears the sequencer, the remainder, the error flag and the output valid,
// and sets the modulus to 65521. A stalled hash output holds back only the next
// last character, which waits with its result until the output register frees.

`include "horner_string_hash_mod_assert.svh"

module horner_string_hash_mod
    import hshm_pkg::*;
#(
    parameter int unsigned HASH_WIDTH = HASH_WIDTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              char_valid,
    output logic              char_stall,
    input  char_item_t        char_data,

    output logic              hash_valid,
    input  logic              hash_stall,
    output hash_item_t        hash_data,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // The modulus can use no more bits than the hash holds.
    localparam int unsigned MOD_W = (HASH_WIDTH < MOD_REG_W) ? HASH_WIDTH : MOD_REG_W;
    // Dividend bits: the remainder followed by the character code.
    localparam int unsigned SH_W  = HASH_WIDTH + CODE_W;
    localparam int unsigned CNT_W = $clog2(SH_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SH_W-1:0]       sh_reg, sh_next;
    logic [MOD_W-1:0]      acc_reg, acc_next;
    logic [MOD_W-1:0]      m_reg, m_next;
    logic                  last_reg, last_next;
    logic [HASH_WIDTH-1:0] rem_reg, rem_next;
    logic                  bad_reg, bad_next;
    logic [MOD_REG_W-1:0]  modulus_reg;
    logic                  hash_valid_reg, hash_valid_next;
    hash_item_t            hash_data_reg, hash_data_next;

    logic                  char_accept;
    logic                  cfg_write;
    logic                  out_free;
    logic [MOD_W-1:0]      m_eff;
    char_code_t            cc;
    logic [MOD_W:0]        trial;
    logic [MOD_W:0]        diff;
    logic [MOD_W-1:0]      step_res;

    assign char_accept = char_valid && !char_stall;
    assign char_stall  = (state_reg != ST_IDLE);
    assign hash_valid  = hash_valid_reg;
    assign hash_data   = hash_data_reg;
    assign out_free    = !hash_valid_reg || !hash_stall;

    // ---------------------------------------------------------------------
    // Configuration port. Register 0 is the modulus; the word index is
    // paddr[2], and writes to any other index are dropped.
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            modulus_reg <= MODULUS_RESET;
        end else if (cfg_write && paddr[2] == REG_MODULUS) begin
            modulus_reg <= pwdata[MOD_REG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MODULUS) begin
            prdata = DATA_W'(modulus_reg);
        end
    end

    // The effective modulus is masked to the hash width, and a zero acts as one.
    always_comb begin
        m_eff = modulus_reg[MOD_W-1:0];
        if (m_eff == '0) begin
            m_eff = MOD_W'(1);
        end
    end

    assign cc = char_code(char_data.character);

    // ---------------------------------------------------------------------
    // Shared reduction unit. Each step shifts the next dividend bit into the
    // partial remainder and subtracts the modulus once if it fits. Because
    // the partial remainder stays below the modulus, one subtract suffices.
    // ---------------------------------------------------------------------
    assign trial    = {acc_reg, sh_reg[SH_W-1]};
    assign diff     = trial - {1'b0, m_reg};
    assign step_res = (trial >= {1'b0, m_reg}) ? diff[MOD_W-1:0] : trial[MOD_W-1:0];

    // ---------------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        sh_next         = sh_reg;
        acc_next        = acc_reg;
        m_next          = m_reg;
        last_next       = last_reg;
        rem_next        = rem_reg;
        bad_next        = bad_reg;
        hash_valid_next = hash_valid_reg;
        hash_data_next  = hash_data_reg;

        if (hash_valid_reg && !hash_stall) begin
            hash_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (char_accept) begin
                    m_next     = m_eff;
                    last_next  = char_data.last_char;
                    bad_next   = bad_reg | cc.bad;
                    state_next = ST_RUN;
                    if (rem_reg < HASH_WIDTH'(m_eff)) begin
                        // Common case: only the six code bits need shifting in.
                        acc_next = rem_reg[MOD_W-1:0];
                        sh_next  = {cc.code, {HASH_WIDTH{1'b0}}};
                        cnt_next = CNT_W'(CODE_W);
                    end else begin
                        // The remainder is at or above the modulus: divide it all.
                        acc_next = '0;
                        sh_next  = {rem_reg, cc.code};
                        cnt_next = CNT_W'(SH_W);
                    end
                end
            end
            ST_RUN: begin
                acc_next = step_res;
                sh_next  = {sh_reg[SH_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    if (!last_reg) begin
                        rem_next   = HASH_WIDTH'(step_res);
                        state_next = ST_IDLE;
                    end else if (out_free) begin
                        hash_valid_next          = 1'b1;
                        hash_data_next.hash_value = OUT_W'(step_res);
                        hash_data_next.bad_char  = bad_reg;
                        rem_next                 = '0;
                        bad_next                 = 1'b0;
                        state_next               = ST_IDLE;
                    end else begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                // The finished hash sits in the accumulator until the output frees.
                if (out_free) begin
                    hash_valid_next          = 1'b1;
                    hash_data_next.hash_value = OUT_W'(acc_reg);
                    hash_data_next.bad_char  = bad_reg;
                    rem_next                 = '0;
                    bad_next                 = 1'b0;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rem_reg        <= '0;
            bad_reg        <= 1'b0;
            hash_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rem_reg        <= rem_next;
            bad_reg        <= bad_next;
            hash_valid_reg <= hash_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        sh_reg        <= sh_next;
        acc_reg       <= acc_next;
        m_reg         <= m_next;
        last_reg      <= last_next;
        hash_data_reg <= hash_data_next;
    end

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    `HSHM_ASSERT_NEXT(a_accept_starts_run, char_accept, state_reg == ST_RUN,
        "accepted character did not start the reduction")
    `HSHM_ASSERT_SAME(a_run_count_live, state_reg == ST_RUN, cnt_reg != '0,
        "reduction running with an exhausted step count")
    `HSHM_ASSERT_SAME(a_partial_below_mod, state_reg == ST_RUN, acc_reg < m_reg,
        "partial remainder reached the modulus")
    `HSHM_ASSERT_SAME(a_wait_needs_full_out, state_reg == ST_WAIT, hash_valid_reg,
        "waiting for the output while the output register is empty")

endmodule

[dv/horner_string_hash_mod_test.sv]
module horner_string_hash_mod_test;
    import hshm_pkg::*;

    // The block is built with its default hash width, and the checks use the same width.
    localparam int unsigned HASH_W = HASH_WIDTH_DEFAULT;
    localparam logic [63:0] HASH_MASK = (64'd1 << HASH_W) - 64'd1;

    // The modulus is the only register, so it sits at byte address zero.
    localparam logic [ADDR_W-1:0] MODULUS_ADDR = ADDR_W'(4 * REG_MODULUS);

    // The settle wait is sized from the slowest character, one whose remainder must
    // be reduced first, so that any character still in flight settles before the
    // modulus is rewritten.
    localparam int unsigned SETTLE_CYCLES = 2 * (HASH_W + 7);

    localparam int unsigned RANDOM_PHASES     = 12;
    localparam int unsigned ITEMS_PER_PHASE   = 64;
    localparam int unsigned MAX_STRING_LENGTH = 12;
    localparam int unsigned LONG_HOLD_CYCLES  = 400;

    // These are the first and last characters of each class, followed by their
    // neighbors just outside the class.
    localparam int unsigned CLASS_BOUND_COUNT = 12;
    localparam logic [CHAR_W*CLASS_BOUND_COUNT-1:0] CLASS_BOUNDS = {
        CHAR_LOWER_A, CHAR_LOWER_Z, CHAR_UPPER_A, CHAR_UPPER_Z,
        CHAR_DIGIT_0, CHAR_DIGIT_9,
        CHAR_W'(CHAR_LOWER_A - 8'd1), CHAR_W'(CHAR_LOWER_Z + 8'd1),
        CHAR_W'(CHAR_UPPER_A - 8'd1), CHAR_W'(CHAR_UPPER_Z + 8'd1),
        CHAR_W'(CHAR_DIGIT_0 - 8'd1), CHAR_W'(CHAR_DIGIT_9 + 8'd1)
    };

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              char_valid = 1'b0;
    logic              char_stall;
    char_item_t        char_data  = '0;
    logic              hash_valid;
    logic              hash_stall = 1'b0;
    hash_item_t        hash_data;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [DATA_W-1:0] pwdata     = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // This is the testbench's own copy of the hashing state. It advances on every
    // character transfer, and the modulus copy changes on every register write.
    logic [MOD_REG_W-1:0] modulus_copy   = MODULUS_RESET;
    logic [HASH_W-1:0]    remainder_copy = '0;
    logic                 bad_copy       = 1'b0;

    // These are the hashes still owed by the block, oldest first.
    hash_item_t expected_hashes[$];

    int unsigned mismatch_count = 0;

    // These are the largest idle gaps, in cycles, that each side draws before a
    // transfer. A test sets them per phase, and zero gives back-to-back traffic.
    int unsigned send_gap_max = 0;
    int unsigned take_gap_max = 0;

    // A nonzero value asks the hash receiver for one long stall of that many cycles.
    int unsigned receiver_hold = 0;

    horner_string_hash_mod #(
        .HASH_WIDTH (HASH_W)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data),
        .hash_valid (hash_valid),
        .hash_stall (hash_stall),
        .hash_data  (hash_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 clk = ~clk;

    // This maps a character to its 6-bit Horner digit and flags anything that is
    // not a letter or a digit.
    function automatic logic [CODE_W-1:0] alnum_digit(input logic [CHAR_W-1:0] ch,
                                                      output logic not_alnum);
        not_alnum = 1'b0;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            return CODE_W'(ch - CHAR_LOWER_A);
        end
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            return CODE_W'(ch - CHAR_UPPER_A + LETTER_COUNT);
        end
        if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
            return CODE_W'(ch - CHAR_DIGIT_0 + DOUBLE * LETTER_COUNT);
        end
        not_alnum = 1'b1;
        return '0;
    endfunction

    // This performs one Horner step for a transferred character. The last character
    // of a string queues the expected hash and clears the running state.
    function automatic void horner_step(input char_item_t item);
        logic [CODE_W-1:0] digit;
        logic              not_alnum;
        logic [63:0]       divisor;
        logic [63:0]       folded;
        hash_item_t        owed;
        digit   = alnum_digit(item.character, not_alnum);
        divisor = 64'(modulus_copy) & HASH_MASK;
        // A zero modulus acts as one, so every hash comes out zero.
        if (divisor == 64'd0) begin
            divisor = 64'd1;
        end
        if (not_alnum) begin
            bad_copy = 1'b1;
        end
        // The remainder is used as stored, even when a smaller modulus was written
        // in the middle of the string.
        folded         = (64'(remainder_copy) * HORNER_RADIX + 64'(digit)) % divisor;
        remainder_copy = HASH_W'(folded & HASH_MASK);
        if (item.last_char) begin
            owed.hash_value = OUT_W'(remainder_copy);
            owed.bad_char   = bad_copy;
            expected_hashes.push_back(owed);
            remainder_copy = '0;
            bad_copy       = 1'b0;
        end
    endfunction

    // This compares one hash transfer with the oldest owed result.
    function automatic void check_hash(input hash_item_t got);
        hash_item_t want;
        if (expected_hashes.size() == 0) begin
            $display("%0t: hash transfer with none owed: expected nothing, actual %h",
                     $time, got);
            mismatch_count++;
            return;
        end
        want = expected_hashes.pop_front();
        if (got.hash_value !== want.hash_value) begin
            $display("%0t: hash_value: expected %0d, actual %0d",
                     $time, want.hash_value, got.hash_value);
            mismatch_count++;
        end
        if (got.bad_char !== want.bad_char) begin
            $display("%0t: bad_char: expected %b, actual %b",
                     $time, want.bad_char, got.bad_char);
            mismatch_count++;
        end
    endfunction

    // This offers one character after a random idle gap and returns at the edge that
    // transfers it. Valid stays high afterward, so a follow-on character with no gap
    // is offered in the very next cycle. Anything other than sending must first drop
    // valid through wait_hashes_drained.
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= {ch, last};
        do @(posedge clk); while (char_stall);
        horner_step(char_data);
    endtask

    // This sends the characters of a text. When close is set, the final character
    // ends the string.
    task automatic send_text(input string text, input logic close);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i], close && (i == text.len() - 1));
        end
    endtask

    // This holds the sender back until every owed hash has arrived, then lets any
    // character still in flight finish. A string may be left open across this wait.
    task automatic wait_hashes_drained();
        char_valid <= 1'b0;
        do @(posedge clk); while (expected_hashes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // This performs one register transfer, a setup cycle and then the access cycle.
    task automatic apb_transfer(input logic write, input logic [DATA_W-1:0] wdata,
                                output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= MODULUS_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (write) begin
            modulus_copy = wdata[MOD_REG_W-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_modulus_readback();
        logic [DATA_W-1:0] rdata;
        apb_transfer(1'b0, '0, rdata);
        if (rdata[MOD_REG_W-1:0] !== modulus_copy) begin
            $display("%0t: modulus readback: expected %0d, actual %0d",
                     $time, modulus_copy, rdata[MOD_REG_W-1:0]);
            mismatch_count++;
        end
    endtask

    // This rewrites the modulus once the block is idle. Bits above the register
    // width are sent as given, and the block must drop them.
    task automatic set_modulus(input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] unused;
        wait_hashes_drained();
        apb_transfer(1'b1, value, unused);
        check_modulus_readback();
    endtask

    function automatic logic [CHAR_W-1:0] random_char();
        case ($urandom_range(0, 9))
            0, 1:    return CHAR_W'($urandom_range(0, 255));
            2, 3, 4: return CHAR_LOWER_A + CHAR_W'($urandom_range(0, LETTER_COUNT - 1));
            5, 6, 7: return CHAR_UPPER_A + CHAR_W'($urandom_range(0, LETTER_COUNT - 1));
            default: return CHAR_DIGIT_0 + CHAR_W'($urandom_range(0, 9));
        endcase
    endfunction

    // This draws a modulus, with the extremes and small values well represented,
    // and puts noise in the unused upper bits.
    function automatic logic [DATA_W-1:0] random_modulus();
        logic [DATA_W-1:0] noise;
        noise = $urandom & ~DATA_W'({MOD_REG_W{1'b1}});
        case ($urandom_range(0, 6))
            0:       return noise | DATA_W'(1);
            1:       return noise | DATA_W'(16'hFFFF);
            2:       return noise;
            3:       return noise | DATA_W'($urandom_range(2, 100));
            default: return noise | DATA_W'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic int unsigned random_gap_max();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 5;
            default: return 19;
        endcase
    endfunction

    // The hash receiver draws a stall before each transfer, or serves one long hold
    // when a test asks for it, and checks every transfer against the owed results.
    initial begin : hash_sink
        int unsigned stall_cycles;
        @(posedge rst_n);
        forever begin
            if (receiver_hold > 0) begin
                stall_cycles  = receiver_hold;
                receiver_hold = 0;
            end else begin
                stall_cycles = $urandom_range(0, take_gap_max);
            end
            if (stall_cycles > 0) begin
                hash_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
                hash_stall <= 1'b0;
            end
            do @(posedge clk); while (!hash_valid);
            check_hash(hash_data);
        end
    end

    // This checks that reset loads the table-size default and that a plain string
    // hashes with it.
    task automatic test_reset_defaults();
        send_gap_max = 0;
        take_gap_max = 0;
        check_modulus_readback();
        send_text("Hash9", 1'b1);
    endtask

    // Each class boundary and each neighbor just outside it is sent as a string of
    // its own, together with the smallest and largest byte. Two further strings then
    // show that the error flag stays set to the end of its string and is cleared
    // for the next one.
    task automatic test_character_classes();
        send_gap_max = 19;
        take_gap_max = 19;
        for (int i = 0; i < CLASS_BOUND_COUNT; i++) begin
            send_char(CLASS_BOUNDS[i*CHAR_W +: CHAR_W], 1'b1);
        end
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("a#b", 1'b1);
        send_text("Zz9", 1'b1);
    endtask

    // This covers the smallest modulus, a zero modulus (which acts as one) written
    // with garbage in the upper bits, the largest modulus and a tiny even modulus.
    task automatic test_modulus_extremes();
        send_gap_max = 3;
        take_gap_max = 3;
        set_modulus(DATA_W'(1));
        send_text("zZ9", 1'b1);
        set_modulus(32'hA5A5_0000);
        send_text("Qq", 1'b1);
        set_modulus(DATA_W'(16'hFFFF));
        send_text("99999", 1'b1);
        set_modulus(DATA_W'(2));
        send_text("b", 1'b1);
    endtask

    // First the modulus shrinks below a large stored remainder, which forces the
    // block's extra reduction pass. Then the modulus grows in the middle of a string.
    task automatic test_modulus_change_mid_string();
        send_gap_max = 0;
        take_gap_max = 0;
        set_modulus(DATA_W'(16'hFFFF));
        send_text("9999", 1'b0);
        set_modulus(DATA_W'(5));
        send_text("a", 1'b1);
        set_modulus(DATA_W'(3));
        send_text("zz", 1'b0);
        set_modulus(DATA_W'(MODULUS_RESET));
        send_text("Z9", 1'b1);
    endtask

    // The receiver holds off for a long stretch while strings arrive back to back.
    // The output register fills, the next last character is held back and the
    // character input stalls. Afterward the sender pauses until every hash is in.
    task automatic test_output_backpressure();
        send_gap_max  = 0;
        take_gap_max  = 0;
        receiver_hold = LONG_HOLD_CYCLES;
        for (int i = 0; i < 30; i++) begin
            send_char(random_char(), 1'b0);
            send_char(random_char(), 1'b1);
        end
        wait_hashes_drained();
    endtask

    // Random strings, mostly alphanumeric, are sent in phases. Each phase has its
    // own idling and modulus. Now and then the modulus is rewritten partway
    // through a string.
    task automatic test_random_strings();
        int unsigned phase_items;
        int unsigned length;
        int unsigned split;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            send_gap_max = random_gap_max();
            take_gap_max = random_gap_max();
            set_modulus(random_modulus());
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                length = $urandom_range(1, MAX_STRING_LENGTH);
                split  = 0;
                if (length > 1 && $urandom_range(0, 19) == 0) begin
                    split = $urandom_range(1, length - 1);
                end
                for (int i = 0; i < length; i++) begin
                    if (split != 0 && i == split) begin
                        set_modulus(random_modulus());
                    end
                    send_char(random_char(), i == length - 1);
                end
                phase_items += length;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_character_classes();
        test_modulus_extremes();
        test_modulus_change_mid_string();
        test_output_backpressure();
        test_random_strings();
        wait_hashes_drained();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // A correct run needs well under a tenth of this time, even with the worst
    // stalls on both sides.
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/hshm_pkg.sv
hw/rtl/horner_string_hash_mod.sv
dv/horner_string_hash_mod_test.sv
